>>> src/servo_slew_limited_position_macros.svh
// Assertion macros for the servo slew-limited position controller.
// Used by the top level; no other dependencies.
`ifndef SERVO_SLEW_LIMITED_POSITION_MACROS_SVH
`define SERVO_SLEW_LIMITED_POSITION_MACROS_SVH

`ifndef SYNTHESIS

`define SSLP_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("sslp assertion failed");

`define SSLP_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("sslp assertion failed");

`else

`define SSLP_ASSERT_IMPL(label, clk, rst_n, ante, cons)

`define SSLP_ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

>>> src/sslp_pkg.sv
// Package for the servo slew-limited position controller.
// Holds command codes, register indexes, reset values, sequencer types.
`timescale 1ns / 1ps

package sslp_pkg;

    localparam int OPENING_BITS_DEF = 16;

    localparam logic [15:0] MAX_OPENING_RST   = 16'd65535;
    localparam logic [15:0] SPEED_RST         = 16'd100;
    localparam logic [15:0] BOOT_OPENING_RST  = 16'd0;
    localparam logic [15:0] CLOSED_PULSE_RST  = 16'd1000;
    localparam logic [15:0] OPEN_PULSE_RST    = 16'd2000;
    localparam logic [31:0] RELEASE_AFTER_RST = 32'd0;

    localparam logic [2:0] CFG_MAX_OPENING   = 3'd0;
    localparam logic [2:0] CFG_SPEED         = 3'd1;
    localparam logic [2:0] CFG_BOOT_OPENING  = 3'd2;
    localparam logic [2:0] CFG_CLOSED_PULSE  = 3'd3;
    localparam logic [2:0] CFG_OPEN_PULSE    = 3'd4;
    localparam logic [2:0] CFG_RELEASE_AFTER = 3'd5;

    typedef enum logic [1:0] {
        FUNC_INIT   = 2'd0,
        FUNC_SET    = 2'd1,
        FUNC_FREEZE = 2'd2,
        FUNC_TICK   = 2'd3
    } func_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_STEP,
        S_UPDATE,
        S_PMUL,
        S_PDIV_GO,
        S_PDIV_WAIT,
        S_EDIV_GO,
        S_EDIV_WAIT,
        S_DONE
    } seq_state_t;

    typedef struct packed {
        logic ready;
        logic mul_step;
        logic update;
        logic mul_pulse;
        logic div_start;
        logic div_eta;
        logic cap_pulse;
        logic cap_eta;
        logic eta_const;
        logic load_out;
    } seq_ctl_t;

    typedef struct packed {
        logic div_done;
        logic speed_zero;
        logic out_free;
    } seq_stat_t;

endpackage

>>> src/sslp_in_if.sv
// Command channel interface: valid, ready and one command item.
// No dependencies.
`timescale 1ns / 1ps

interface sslp_in_if;
    logic        valid;
    logic        ready;
    logic [1:0]  func;
    logic [15:0] target_opening;
    logic [15:0] elapsed;

    modport source (output valid, func, target_opening, elapsed, input ready);
    modport sink (input valid, func, target_opening, elapsed, output ready);
endinterface

>>> src/sslp_out_if.sv
// Result channel interface: valid, ready and one result item.
// No dependencies.
`timescale 1ns / 1ps

interface sslp_out_if;
    logic        valid;
    logic        ready;
    logic        accepted;
    logic        arrived;
    logic [15:0] position;
    logic [15:0] pulse_width;
    logic        drive_on;
    logic [15:0] time_to_target;

    modport source (output valid, accepted, arrived, position, pulse_width, drive_on,
                    time_to_target, input ready);
    modport sink (input valid, accepted, arrived, position, pulse_width, drive_on,
                  time_to_target, output ready);
endinterface

>>> src/sslp_cfg_if.sv
// Configuration write channel interface: valid, ready, register index and data.
// No dependencies.
`timescale 1ns / 1ps

interface sslp_cfg_if;
    logic        valid;
    logic        ready;
    logic [2:0]  index;
    logic [31:0] data;

    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface

>>> src/sslp_div.sv
// Shared restoring divider, one quotient bit per cycle, 16-bit divisor.
// No package dependencies.
`timescale 1ns / 1ps

module sslp_div #(
    parameter int DW = 32
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    input  logic [DW-1:0]               dividend,
    input  logic [15:0]                 divisor,
    input  logic [$clog2(DW+1)-1:0]     count,
    output logic                        busy,
    output logic                        done,
    output logic [DW-1:0]               quotient,
    output logic [15:0]                 remainder
);

    localparam int CW = $clog2(DW + 1);

    logic            busy_reg, busy_next;
    logic            done_reg, done_next;
    logic [CW-1:0]   cnt_reg, cnt_next;
    logic [DW-1:0]   q_reg, q_next;
    logic [15:0]     r_reg, r_next;
    logic [15:0]     d_reg, d_next;
    logic [16:0]     trial;
    logic            ge;

    assign trial = {r_reg, q_reg[DW-1]};
    assign ge    = trial >= {1'b0, d_reg};

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        q_next    = q_reg;
        r_next    = r_reg;
        d_next    = d_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = count;
            q_next    = dividend;
            r_next    = 16'd0;
            d_next    = divisor;
        end
        else if (busy_reg)
        begin
            q_next   = {q_reg[DW-2:0], ge};
            r_next   = ge ? 16'(trial - {1'b0, d_reg}) : trial[15:0];
            cnt_next = cnt_reg - CW'(1);
            if (cnt_reg == CW'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        q_reg <= q_next;
        r_reg <= r_next;
        d_reg <= d_next;
    end

    assign busy      = busy_reg;
    assign done      = done_reg;
    assign quotient  = q_reg;
    assign remainder = r_reg;

endmodule

>>> src/sslp_seq.sv
// Sequencer for the servo controller: steps one command through multiply, update,
// pulse multiply and the divisions (one at zero speed). Depends on sslp_pkg.
`timescale 1ns / 1ps

module sslp_seq (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cmd_valid,
    input  sslp_pkg::seq_stat_t stat,
    output sslp_pkg::seq_ctl_t  ctl
);

    import sslp_pkg::*;

    seq_state_t state_reg, state_next;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:      if (cmd_valid) state_next = S_STEP;
            S_STEP:      state_next = S_UPDATE;
            S_UPDATE:    state_next = S_PMUL;
            S_PMUL:      state_next = S_PDIV_GO;
            S_PDIV_GO:   state_next = S_PDIV_WAIT;
            S_PDIV_WAIT: if (stat.div_done) state_next = S_EDIV_GO;
            S_EDIV_GO:   state_next = stat.speed_zero ? S_DONE : S_EDIV_WAIT;
            S_EDIV_WAIT: if (stat.div_done) state_next = S_DONE;
            S_DONE:      if (stat.out_free) state_next = S_IDLE;
            default:     state_next = S_IDLE;
        endcase
    end

    always_comb
    begin
        ctl           = '0;
        ctl.ready     = state_reg == S_IDLE;
        ctl.mul_step  = state_reg == S_STEP;
        ctl.update    = state_reg == S_UPDATE;
        ctl.mul_pulse = state_reg == S_PMUL;
        ctl.div_start = (state_reg == S_PDIV_GO)
                        || (state_reg == S_EDIV_GO && !stat.speed_zero);
        ctl.div_eta   = state_reg == S_EDIV_GO;
        ctl.cap_pulse = state_reg == S_PDIV_WAIT && stat.div_done;
        ctl.cap_eta   = state_reg == S_EDIV_WAIT && stat.div_done;
        ctl.eta_const = state_reg == S_EDIV_GO && stat.speed_zero;
        ctl.load_out  = state_reg == S_DONE && stat.out_free;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_IDLE;
        else
            state_reg <= state_next;
    end

endmodule

>>> src/servo_slew_limited_position.sv
// Servo slew-limited position controller: top level with datapath and registers.
// A command runs through the shared bit-serial divider, first for the pulse width and then
// for the time to target; zero speed skips the second run. A new command is taken only
// after the previous result is loaded; a waiting result holds the sequencer in its last
// step. Reset is asynchronous and clears state.
`timescale 1ns / 1ps
`include "servo_slew_limited_position_macros.svh"

module servo_slew_limited_position #(
    parameter int OPENING_BITS = sslp_pkg::OPENING_BITS_DEF
) (
    input logic       clk,
    input logic       rst_n,
    sslp_cfg_if.sink  cfg,
    sslp_in_if.sink   cmd,
    sslp_out_if.source rsp
);

    import sslp_pkg::*;

    localparam int OB = OPENING_BITS;
    localparam int MW = (OB > 16) ? OB : 16;
    localparam int PW = MW + 16;
    localparam int DW = OB + 16;
    localparam int CW = $clog2(DW + 1);
    localparam int EW = DW + 2;

    seq_ctl_t  ctl;
    seq_stat_t stat;

    logic [15:0] max_reg, speed_reg, boot_reg, closed_reg, open_reg;
    logic [31:0] release_reg;

    logic [OB-1:0] pos_reg, pos_next;
    logic [OB-1:0] goal_reg, goal_next;
    logic [31:0]   idle_reg, idle_next;
    logic          pend_reg, pend_next;

    logic [1:0]  func_reg;
    logic [15:0] tgt_reg, dt_reg;
    logic        acc_reg, acc_next;
    logic        arr_reg, arr_next;
    logic [PW-1:0] prod_reg;
    logic          neg_reg;
    logic [15:0]   pulse_reg, eta_reg;

    logic        rsp_valid_reg;
    logic        rsp_acc_reg, rsp_arr_reg, rsp_drive_reg;
    logic [15:0] rsp_pos_reg, rsp_pulse_reg, rsp_eta_reg;

    logic [OB-1:0] gap;
    logic [31:0]   pos32, speed32, boot32, tgt32;
    logic [15:0]   diff_mag;
    logic [MW-1:0] mul_a;
    logic [15:0]   mul_b;
    logic [PW-1:0] prod_full;
    logic [32:0]   idle_sum;
    logic [15:0]   max_or1;

    logic [DW-1:0] div_dividend, div_q;
    logic [15:0]   div_divisor, div_r;
    logic [CW-1:0] div_count;
    logic          div_busy, div_done;

    logic [EW-1:0] qq, closed_e, sum_e;
    logic [15:0]   pulse_val, eta_val;

    // Configuration registers.
    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_reg     <= MAX_OPENING_RST;
            speed_reg   <= SPEED_RST;
            boot_reg    <= BOOT_OPENING_RST;
            closed_reg  <= CLOSED_PULSE_RST;
            open_reg    <= OPEN_PULSE_RST;
            release_reg <= RELEASE_AFTER_RST;
        end
        else if (cfg.valid)
        begin
            unique case (cfg.index)
                CFG_MAX_OPENING:   max_reg     <= cfg.data[15:0];
                CFG_SPEED:         speed_reg   <= cfg.data[15:0];
                CFG_BOOT_OPENING:  boot_reg    <= cfg.data[15:0];
                CFG_CLOSED_PULSE:  closed_reg  <= cfg.data[15:0];
                CFG_OPEN_PULSE:    open_reg    <= cfg.data[15:0];
                CFG_RELEASE_AFTER: release_reg <= cfg.data;
                default:           ;
            endcase
        end
    end

    sslp_seq u_seq (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd.valid),
        .stat      (stat),
        .ctl       (ctl)
    );

    assign cmd.ready       = ctl.ready;
    assign stat.div_done   = div_done;
    assign stat.speed_zero = speed_reg == 16'd0;
    assign stat.out_free   = !rsp_valid_reg || rsp.ready;

    always_ff @(posedge clk)
    begin
        if (cmd.valid && ctl.ready)
        begin
            func_reg <= cmd.func;
            tgt_reg  <= cmd.target_opening;
            dt_reg   <= cmd.elapsed;
        end
    end

    assign pos32    = {{(32 - OB){1'b0}}, pos_reg};
    assign speed32  = {16'd0, speed_reg};
    assign boot32   = {16'd0, boot_reg};
    assign tgt32    = {16'd0, tgt_reg};
    assign gap      = (goal_reg > pos_reg) ? OB'(goal_reg - pos_reg) : OB'(pos_reg - goal_reg);
    assign diff_mag = (open_reg >= closed_reg) ? 16'(open_reg - closed_reg)
                                               : 16'(closed_reg - open_reg);
    assign idle_sum = {1'b0, idle_reg} + {17'd0, dt_reg};
    assign max_or1  = (max_reg == 16'd0) ? 16'd1 : max_reg;

    // The one multiplier serves the slew step and the pulse interpolation.
    assign mul_a     = ctl.mul_pulse ? pos32[MW-1:0] : speed32[MW-1:0];
    assign mul_b     = ctl.mul_pulse ? diff_mag : dt_reg;
    assign prod_full = {16'd0, mul_a} * {{(PW - 16){1'b0}}, mul_b};

    always_ff @(posedge clk)
    begin
        if (ctl.mul_step || ctl.mul_pulse)
            prod_reg <= prod_full;
        if (ctl.mul_pulse)
            neg_reg <= closed_reg > open_reg;
    end

    always_comb
    begin
        pos_next  = pos_reg;
        goal_next = goal_reg;
        idle_next = idle_reg;
        pend_next = pend_reg;
        acc_next  = 1'b1;
        arr_next  = 1'b0;
        unique case (func_t'(func_reg))
            FUNC_INIT:
            begin
                pos_next  = boot32[OB-1:0];
                goal_next = boot32[OB-1:0];
                idle_next = 32'd0;
                pend_next = 1'b0;
            end
            FUNC_SET:
            begin
                if (tgt_reg <= max_reg && tgt32[31:OB] == '0)
                begin
                    goal_next = tgt32[OB-1:0];
                    idle_next = 32'd0;
                    pend_next = 1'b1;
                end
                else
                    acc_next = 1'b0;
            end
            FUNC_FREEZE:
            begin
                goal_next = pos_reg;
                idle_next = 32'd0;
                pend_next = 1'b0;
            end
            FUNC_TICK:
            begin
                if (dt_reg != 16'd0 && pos_reg != goal_reg)
                begin
                    if ({{(PW - OB){1'b0}}, gap} <= prod_reg)
                        pos_next = goal_reg;
                    else if (goal_reg > pos_reg)
                        pos_next = OB'(pos_reg + prod_reg[OB-1:0]);
                    else
                        pos_next = OB'(pos_reg - prod_reg[OB-1:0]);
                    idle_next = 32'd0;
                end
                else
                    idle_next = idle_sum[32] ? 32'hFFFF_FFFF : idle_sum[31:0];
                if (pend_reg && pos_next == goal_reg)
                begin
                    pend_next = 1'b0;
                    arr_next  = 1'b1;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg  <= '0;
            goal_reg <= '0;
            idle_reg <= 32'd0;
            pend_reg <= 1'b0;
        end
        else if (ctl.update)
        begin
            pos_reg  <= pos_next;
            goal_reg <= goal_next;
            idle_reg <= idle_next;
            pend_reg <= pend_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.update)
        begin
            acc_reg <= acc_next;
            arr_reg <= arr_next;
        end
    end

    // The divider runs the pulse numerator over the full width, then the distance
    // left-aligned so that only the opening bits are iterated.
    assign div_dividend = ctl.div_eta ? {gap, 16'd0} : prod_reg[DW-1:0];
    assign div_divisor  = ctl.div_eta ? speed_reg : max_or1;
    assign div_count    = ctl.div_eta ? CW'(OB) : CW'(DW);

    sslp_div #(
        .DW (DW)
    ) u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (ctl.div_start),
        .dividend  (div_dividend),
        .divisor   (div_divisor),
        .count     (div_count),
        .busy      (div_busy),
        .done      (div_done),
        .quotient  (div_q),
        .remainder (div_r)
    );

    // A negative numerator rounds toward minus infinity.
    assign qq       = {2'b00, div_q} + EW'(neg_reg && div_r != 16'd0);
    assign closed_e = {{(EW - 16){1'b0}}, closed_reg};
    assign sum_e    = neg_reg ? (closed_e - qq) : (closed_e + qq);

    always_comb
    begin
        if (neg_reg)
            pulse_val = (qq > closed_e) ? 16'd0 : sum_e[15:0];
        else
            pulse_val = (sum_e[EW-1:16] != '0) ? 16'hFFFF : sum_e[15:0];
    end

    assign eta_val = (div_q[DW-1:16] != '0) ? 16'hFFFF : div_q[15:0];

    always_ff @(posedge clk)
    begin
        if (ctl.cap_pulse)
            pulse_reg <= pulse_val;
        if (ctl.cap_eta)
            eta_reg <= eta_val;
        else if (ctl.eta_const)
            eta_reg <= (gap != '0) ? 16'hFFFF : 16'd0;
    end

    // Output register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            rsp_valid_reg <= 1'b0;
        else if (ctl.load_out)
            rsp_valid_reg <= 1'b1;
        else if (rsp.ready)
            rsp_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (ctl.load_out)
        begin
            rsp_acc_reg   <= acc_reg;
            rsp_arr_reg   <= arr_reg;
            rsp_pos_reg   <= pos32[15:0];
            rsp_pulse_reg <= pulse_reg;
            rsp_drive_reg <= (release_reg == 32'd0) || (idle_reg < release_reg);
            rsp_eta_reg   <= eta_reg;
        end
    end

    assign rsp.valid          = rsp_valid_reg;
    assign rsp.accepted       = rsp_acc_reg;
    assign rsp.arrived        = rsp_arr_reg;
    assign rsp.position       = rsp_pos_reg;
    assign rsp.pulse_width    = rsp_pulse_reg;
    assign rsp.drive_on       = rsp_drive_reg;
    assign rsp.time_to_target = rsp_eta_reg;

    `SSLP_ASSERT_NEXT(a_one_item_at_a_time, clk, rst_n, cmd.valid && cmd.ready, !cmd.ready)
    `SSLP_ASSERT_IMPL(a_div_start_when_free, clk, rst_n, ctl.div_start, !div_busy)
    `SSLP_ASSERT_NEXT(a_init_clears_pending, clk, rst_n, ctl.update && func_reg == FUNC_INIT, !pend_reg)
    `SSLP_ASSERT_IMPL(a_load_only_when_free, clk, rst_n, ctl.load_out, !rsp_valid_reg || rsp.ready)

endmodule
